// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/cra_pkg.sv =====
// ----------------------------------------------------------------------------
// cra_pkg
// Shared constants and codes for the compacting region allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cra_pkg;

  localparam int POOL_BYTES_DEF    = 1024;
  localparam int HEADER_BYTES_DEF  = 8;
  localparam int MAX_BLOCKS_DEF    = 16;
  localparam int RECLAIM_DEPTH_DEF = 8;

  localparam int HANDLE_W = 16;
  localparam int SIZE_W   = 16;
  localparam int OUT_OFF_W = 10;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_QUEUE   = 2'd2,
    CMD_RECLAIM = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NO_ROOM  = 3'd1,
    STS_NOTFOUND = 3'd2,
    STS_FULL     = 3'd3,
    STS_EMPTY    = 3'd4
  } status_t;

endpackage

// ===== hw/rtl/cra_ram.sv =====
// ----------------------------------------------------------------------------
// cra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/compacting_region_allocator.sv =====
// Allocate, queue and trivially refused commands go from idle to the answer
// state; reclaim first reads the popped handle in its own state. Free and reclaim
// search the table newest first, move each later block with a read and a write
// state, then update the counts in a finish state; moves and answers wait for a
// free output register. One command at a time; the next word waits for the answer.
// Synchronous active-low reset; table and reclaim RAMs need no clearing pass.
// ----------------------------------------------------------------------------
// compacting_region_allocator
// Handle table for a byte pool with compaction on free and a LIFO reclaim
// list; emits one relocation word per moved block, then a command answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module compacting_region_allocator #(
  parameter int POOL_BYTES    = cra_pkg::POOL_BYTES_DEF,
  parameter int HEADER_BYTES  = cra_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS    = cra_pkg::MAX_BLOCKS_DEF,
  parameter int RECLAIM_DEPTH = cra_pkg::RECLAIM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // handle[15:0], size[31:16]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status[2:0], owner[18:3], new_offset[28:19],
                                  // old_offset[38:29], move_length[48:39], zero pad
  output logic        out_tuser,  // kind
  output logic        out_tlast   // last
);

  import cra_pkg::*;

  localparam int OW  = $clog2(POOL_BYTES + 1);
  localparam int LW  = (POOL_BYTES > 2) ? $clog2(POOL_BYTES) : 1;
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int TAW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int RCW = $clog2(RECLAIM_DEPTH + 1);
  localparam int RAW = (RECLAIM_DEPTH > 1) ? $clog2(RECLAIM_DEPTH) : 1;
  localparam int ENT_W = HANDLE_W + OW + LW;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_RCL       = 8'b0000_0010,
    S_SRCH_RD   = 8'b0000_0100,
    S_SRCH_CMP  = 8'b0000_1000,
    S_SHIFT_RD  = 8'b0001_0000,
    S_SHIFT_WR  = 8'b0010_0000,
    S_FINISH    = 8'b0100_0000,
    S_ANSWER    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]       blk_cnt_r, blk_cnt_nxt;
  logic [OW-1:0]       end_off_r, end_off_nxt;
  logic [OW-1:0]       bytes_left_r, bytes_left_nxt;
  logic [RCW-1:0]      rcl_cnt_r, rcl_cnt_nxt;
  logic [HANDLE_W-1:0] hnd_r, hnd_nxt;
  logic [TAW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [LW-1:0]       freed_r, freed_nxt;
  status_t             ans_status_r, ans_status_nxt;
  logic [HANDLE_W-1:0] ans_owner_r, ans_owner_nxt;
  logic [OW-1:0]       ans_off_r, ans_off_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic                out_last_r, out_last_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_owner_r, out_owner_nxt;
  logic [OUT_OFF_W-1:0] out_new_r, out_new_nxt;
  logic [OUT_OFF_W-1:0] out_old_r, out_old_nxt;
  logic [OUT_OFF_W-1:0] out_len_r, out_len_nxt;

  // table RAM
  logic             tbl_we;
  logic [TAW-1:0]   tbl_waddr, tbl_raddr;
  logic [ENT_W-1:0] tbl_wdata, tbl_rdata;
  logic [HANDLE_W-1:0] tbl_rd_owner;
  logic [OW-1:0]       tbl_rd_off;
  logic [LW-1:0]       tbl_rd_len;
  logic [OW-1:0]       shift_off;

  // reclaim RAM
  logic                rcl_we;
  logic [RAW-1:0]      rcl_waddr, rcl_raddr;
  logic [HANDLE_W-1:0] rcl_rdata;

  cmd_t                in_cmd;
  logic [HANDLE_W-1:0] in_handle;
  logic [SIZE_W-1:0]   in_size;
  logic [SIZE_W:0]     alloc_cost;
  logic                alloc_refuse;
  logic                out_free;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_handle = in_tdata[15:0];
  assign in_size   = in_tdata[31:16];

  assign alloc_cost   = {1'b0, in_size} + (SIZE_W+1)'(HEADER_BYTES);
  assign alloc_refuse = ({1'b0, in_size} >= (SIZE_W+1)'(POOL_BYTES)) ||
                        (blk_cnt_r >= CW'(MAX_BLOCKS)) ||
                        (alloc_cost > (SIZE_W+1)'(bytes_left_r));

  assign tbl_rd_owner = tbl_rdata[ENT_W-1 -: HANDLE_W];
  assign tbl_rd_off   = tbl_rdata[LW +: OW];
  assign tbl_rd_len   = tbl_rdata[LW-1:0];
  assign shift_off    = tbl_rd_off - OW'(freed_r);

  // search reads the candidate entry, the shift reads the block being moved
  assign tbl_raddr = (state_r == S_SRCH_RD || state_r == S_SRCH_CMP) ? idx_r
                                                                      : TAW'(j_r);
  assign rcl_raddr = RAW'(rcl_cnt_r - 1'b1);
  assign rcl_waddr = RAW'(rcl_cnt_r);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    blk_cnt_nxt    = blk_cnt_r;
    end_off_nxt    = end_off_r;
    bytes_left_nxt = bytes_left_r;
    rcl_cnt_nxt    = rcl_cnt_r;
    hnd_nxt        = hnd_r;
    idx_nxt        = idx_r;
    j_nxt          = j_r;
    freed_nxt      = freed_r;
    ans_status_nxt = ans_status_r;
    ans_owner_nxt  = ans_owner_r;
    ans_off_nxt    = ans_off_r;
    tbl_we         = 1'b0;
    tbl_waddr      = TAW'(j_r - 1'b1);
    tbl_wdata      = {tbl_rd_owner, shift_off, tbl_rd_len};
    rcl_we         = 1'b0;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_owner_nxt  = out_owner_r;
    out_new_nxt    = out_new_r;
    out_old_nxt    = out_old_r;
    out_len_nxt    = out_len_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ans_owner_nxt = in_handle;
          ans_off_nxt   = '0;
          state_nxt     = S_ANSWER;
          case (in_cmd)
            CMD_ALLOC: begin
              if (alloc_refuse) begin
                ans_status_nxt = STS_NO_ROOM;
              end else begin
                tbl_we         = 1'b1;
                tbl_waddr      = TAW'(blk_cnt_r);
                tbl_wdata      = {in_handle, end_off_r, LW'(in_size)};
                blk_cnt_nxt    = blk_cnt_r + 1'b1;
                end_off_nxt    = end_off_r + OW'(in_size);
                bytes_left_nxt = OW'((SIZE_W+1)'(bytes_left_r) - alloc_cost);
                ans_status_nxt = STS_OK;
                ans_off_nxt    = end_off_r;
              end
            end
            CMD_FREE: begin
              if (in_handle == '0 || blk_cnt_r == '0) begin
                ans_status_nxt = STS_NOTFOUND;
              end else begin
                hnd_nxt   = in_handle;
                idx_nxt   = TAW'(blk_cnt_r - 1'b1);
                state_nxt = S_SRCH_RD;
              end
            end
            CMD_QUEUE: begin
              if (rcl_cnt_r >= RCW'(RECLAIM_DEPTH)) begin
                ans_status_nxt = STS_FULL;
              end else begin
                rcl_we         = 1'b1;
                rcl_cnt_nxt    = rcl_cnt_r + 1'b1;
                ans_status_nxt = STS_OK;
              end
            end
            CMD_RECLAIM: begin
              if (rcl_cnt_r == '0) begin
                ans_status_nxt = STS_EMPTY;
                ans_owner_nxt  = '0;
              end else begin
                // pop now; the read issued this cycle returns the handle
                rcl_cnt_nxt = rcl_cnt_r - 1'b1;
                state_nxt   = S_RCL;
              end
            end
            default: begin
              ans_status_nxt = STS_NOTFOUND;
            end
          endcase
        end
      end
      S_RCL: begin
        if (rcl_rdata == '0 || blk_cnt_r == '0) begin
          ans_status_nxt = STS_NOTFOUND;
          ans_owner_nxt  = rcl_rdata;
          ans_off_nxt    = '0;
          state_nxt      = S_ANSWER;
        end else begin
          hnd_nxt   = rcl_rdata;
          idx_nxt   = TAW'(blk_cnt_r - 1'b1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (tbl_rd_owner == hnd_r) begin
          freed_nxt = tbl_rd_len;
          j_nxt     = CW'(idx_r) + 1'b1;
          state_nxt = (CW'(CW'(idx_r) + 1'b1) == blk_cnt_r) ? S_FINISH : S_SHIFT_RD;
        end else if (idx_r == '0) begin
          ans_status_nxt = STS_NOTFOUND;
          ans_owner_nxt  = hnd_r;
          ans_off_nxt    = '0;
          state_nxt      = S_ANSWER;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        if (out_free) begin
          tbl_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = 1'b1;
          out_last_nxt   = 1'b0;
          out_status_nxt = STS_OK;
          out_owner_nxt  = tbl_rd_owner;
          out_new_nxt    = OUT_OFF_W'(shift_off);
          out_old_nxt    = OUT_OFF_W'(tbl_rd_off);
          out_len_nxt    = OUT_OFF_W'(tbl_rd_len);
          j_nxt          = j_r + 1'b1;
          state_nxt      = (CW'(j_r + 1'b1) == blk_cnt_r) ? S_FINISH : S_SHIFT_RD;
        end
      end
      S_FINISH: begin
        blk_cnt_nxt    = blk_cnt_r - 1'b1;
        end_off_nxt    = end_off_r - OW'(freed_r);
        bytes_left_nxt = bytes_left_r + OW'(freed_r) + OW'(HEADER_BYTES);
        ans_status_nxt = STS_OK;
        ans_owner_nxt  = hnd_r;
        ans_off_nxt    = '0;
        state_nxt      = S_ANSWER;
      end
      S_ANSWER: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = 1'b0;
          out_last_nxt   = 1'b1;
          out_status_nxt = ans_status_r;
          out_owner_nxt  = ans_owner_r;
          out_new_nxt    = OUT_OFF_W'(ans_off_r);
          out_old_nxt    = '0;
          out_len_nxt    = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      blk_cnt_r    <= '0;
      end_off_r    <= '0;
      bytes_left_r <= OW'(POOL_BYTES);
      rcl_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      blk_cnt_r    <= blk_cnt_nxt;
      end_off_r    <= end_off_nxt;
      bytes_left_r <= bytes_left_nxt;
      rcl_cnt_r    <= rcl_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hnd_r        <= hnd_nxt;
    idx_r        <= idx_nxt;
    j_r          <= j_nxt;
    freed_r      <= freed_nxt;
    ans_status_r <= ans_status_nxt;
    ans_owner_r  <= ans_owner_nxt;
    ans_off_r    <= ans_off_nxt;
    out_kind_r   <= out_kind_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_owner_r  <= out_owner_nxt;
    out_new_r    <= out_new_nxt;
    out_old_r    <= out_old_nxt;
    out_len_r    <= out_len_nxt;
  end

  cra_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  cra_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (RECLAIM_DEPTH)
  ) u_rcl (
    .clk   (clk),
    .we    (rcl_we),
    .waddr (rcl_waddr),
    .wdata (in_handle),
    .raddr (rcl_raddr),
    .rdata (rcl_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_len_r, out_old_r, out_new_r, out_owner_r, out_status_r};

  // pool accounting: used bytes, headers and free bytes always add up
  `ASSERT_PROP(a_pool_balance, clk, rst_n,
    32'(end_off_r) + 32'(bytes_left_r) + 32'(HEADER_BYTES) * 32'(blk_cnt_r) == 32'(POOL_BYTES))
  // a relocation word never closes a command
  `ASSERT_IMPL(a_reloc_not_last, clk, rst_n, out_tvalid && out_tuser, !out_tlast)
  // the block being moved is always inside the live table
  `ASSERT_IMPL(a_shift_in_range, clk, rst_n,
    state_r == S_SHIFT_WR || state_r == S_SHIFT_RD, j_r < blk_cnt_r)

endmodule

// ===== test/tb_compacting_region_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_compacting_region_allocator
// Self-checking bench for the compacting region allocator. A short table of
// directed commands (refusals, null and duplicate handles, reclaim list
// full/empty) is followed by random alloc/free/queue/reclaim traffic with
// table-fill bursts aimed at the longest relocation runs. Every output word
// is checked against a behavioural model of the pool or a row's answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_compacting_region_allocator;
  import cra_pkg::*;

  localparam int POOL  = POOL_BYTES_DEF;
  localparam int HDR   = HEADER_BYTES_DEF;
  localparam int MAXB  = MAX_BLOCKS_DEF;
  localparam int DEPTH = RECLAIM_DEPTH_DEF;
  localparam int RAND_ITEMS = 205;

  typedef struct packed {
    logic          kind;
    status_t       status;
    logic [15:0]   owner;
    logic [9:0]    new_off;
    logic [9:0]    old_off;
    logic [9:0]    mlen;
    logic          last;
  } pool_word_t;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] handle;
    logic [15:0] size;
    bit          typed;
    pool_word_t  answer;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  compacting_region_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // pool model state
  logic [15:0] tbl_owner [MAXB];
  int          tbl_off   [MAXB];
  int          tbl_len   [MAXB];
  int          blk_cnt;
  int          end_off;
  int          room_left;
  logic [15:0] rq_list   [DEPTH];
  int          rq_cnt;

  pool_word_t  step_q[$];     // words caused by the command being modelled
  pool_word_t  pending_q[$];  // words still owed by the block
  stim_row_t   dir_rows[$];

  int err_cnt;
  bit idle_on;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic pool_word_t cmd_answer(status_t st, logic [15:0] own, int noff);
    cmd_answer = '{kind: 1'b0, status: st, owner: own, new_off: 10'(noff),
                   old_off: 10'd0, mlen: 10'd0, last: 1'b1};
  endfunction

  function automatic void pool_free(logic [15:0] h);
    int pos;
    int freed;
    int i;
    pos = -1;
    if (h != 16'd0) begin
      for (i = blk_cnt - 1; i >= 0; i--)
        if (pos < 0 && tbl_owner[i] == h) pos = i;
    end
    if (pos < 0) begin
      step_q.push_back(cmd_answer(STS_NOTFOUND, h, 0));
      return;
    end
    freed = tbl_len[pos];
    // newer blocks slide down, oldest first
    for (i = pos + 1; i < blk_cnt; i++) begin
      step_q.push_back('{kind: 1'b1, status: STS_OK, owner: tbl_owner[i],
                         new_off: 10'(tbl_off[i] - freed), old_off: 10'(tbl_off[i]),
                         mlen: 10'(tbl_len[i]), last: 1'b0});
      tbl_owner[i-1] = tbl_owner[i];
      tbl_off[i-1]   = tbl_off[i] - freed;
      tbl_len[i-1]   = tbl_len[i];
    end
    blk_cnt--;
    end_off   -= freed;
    room_left += freed + HDR;
    step_q.push_back(cmd_answer(STS_OK, h, 0));
  endfunction

  function automatic void pool_step(cmd_t c, logic [15:0] h, logic [15:0] s);
    int sz;
    sz = int'(s);
    case (c)
      CMD_ALLOC: begin
        if (sz >= POOL || blk_cnt >= MAXB || sz + HDR > room_left) begin
          step_q.push_back(cmd_answer(STS_NO_ROOM, h, 0));
        end else begin
          tbl_owner[blk_cnt] = h;
          tbl_off[blk_cnt]   = end_off;
          tbl_len[blk_cnt]   = sz;
          blk_cnt++;
          step_q.push_back(cmd_answer(STS_OK, h, end_off));
          end_off   += sz;
          room_left -= sz + HDR;
        end
      end
      CMD_FREE: pool_free(h);
      CMD_QUEUE: begin
        if (rq_cnt >= DEPTH) begin
          step_q.push_back(cmd_answer(STS_FULL, h, 0));
        end else begin
          rq_list[rq_cnt] = h;
          rq_cnt++;
          step_q.push_back(cmd_answer(STS_OK, h, 0));
        end
      end
      default: begin
        if (rq_cnt == 0) begin
          step_q.push_back(cmd_answer(STS_EMPTY, 16'd0, 0));
        end else begin
          rq_cnt--;
          pool_free(rq_list[rq_cnt]);
        end
      end
    endcase
  endfunction

  function automatic void add_row(cmd_t c, logic [15:0] h, logic [15:0] s, bit typed,
                                  status_t st, logic [15:0] own, int noff);
    stim_row_t r;
    r.cmd    = c;
    r.handle = h;
    r.size   = s;
    r.typed  = typed;
    r.answer = cmd_answer(st, own, noff);
    dir_rows.push_back(r);
  endfunction

  function automatic logic [15:0] rand_handle();
    if ($urandom_range(0, 19) == 0) return 16'd0;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [15:0] live_or_rand();
    if (blk_cnt > 0 && $urandom_range(0, 9) < 7)
      return tbl_owner[$urandom_range(0, blk_cnt - 1)];
    return rand_handle();
  endfunction

  // present one command word; model it at the edge it is taken
  task automatic send_word(cmd_t c, logic [15:0] h, logic [15:0] s, bit typed,
                           pool_word_t typed_ans);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s, h};
    in_tuser  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pool_step(c, h, s);
    if (typed) begin
      step_q.delete();
      step_q.push_back(typed_ans);
    end
    while (step_q.size() > 0) pending_q.push_back(step_q.pop_front());
  endtask

  // result side back-pressure
  initial begin : ready_gen
    int gap;
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 6);
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    pool_word_t got;
    pool_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{kind: out_tuser, status: status_t'(out_tdata[2:0]),
              owner: out_tdata[18:3], new_off: out_tdata[28:19],
              old_off: out_tdata[38:29], mlen: out_tdata[48:39], last: out_tlast};
      if (pending_q.size() == 0) begin
        if (err_cnt < 10)
          $display("unexpected word: kind=%0d status=%0d owner=%h new=%0d old=%0d len=%0d last=%0d",
                   got.kind, got.status, got.owner, got.new_off, got.old_off, got.mlen,
                   got.last);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (got.kind !== want.kind || got.status !== want.status ||
            got.owner !== want.owner || got.new_off !== want.new_off ||
            got.old_off !== want.old_off || got.mlen !== want.mlen ||
            got.last !== want.last) begin
          if (err_cnt < 10) begin
            $display("mismatch exp: kind=%0d status=%0d owner=%h new=%0d old=%0d len=%0d last=%0d",
                     want.kind, want.status, want.owner, want.new_off, want.old_off,
                     want.mlen, want.last);
            $display("         got: kind=%0d status=%0d owner=%h new=%0d old=%0d len=%0d last=%0d",
                     got.kind, got.status, got.owner, got.new_off, got.old_off, got.mlen,
                     got.last);
          end
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main
    int          n;
    int          r;
    int          fill_left;
    bit          drain_oldest;
    cmd_t        c;
    logic [15:0] h;
    logic [15:0] s;
    pool_word_t  no_ans;

    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    rst_n     = 1'b0;
    err_cnt   = 0;
    idle_on   = 1'b1;
    blk_cnt   = 0;
    end_off   = 0;
    room_left = POOL;
    rq_cnt    = 0;
    fill_left = 0;
    drain_oldest = 1'b0;
    no_ans    = cmd_answer(STS_OK, 16'd0, 0);

    add_row(CMD_RECLAIM, 16'h0000, 16'h0000, 1, STS_EMPTY,    16'h0000, 0);
    add_row(CMD_FREE,    16'h0005, 16'h00aa, 1, STS_NOTFOUND, 16'h0005, 0);
    add_row(CMD_ALLOC,   16'h0001, 16'h0000, 1, STS_OK,       16'h0001, 0);
    add_row(CMD_ALLOC,   16'hffff, 16'd1023, 1, STS_NO_ROOM,  16'hffff, 0);
    add_row(CMD_ALLOC,   16'h0002, 16'hffff, 1, STS_NO_ROOM,  16'h0002, 0);
    add_row(CMD_ALLOC,   16'h0002, 16'd1024, 1, STS_NO_ROOM,  16'h0002, 0);
    add_row(CMD_ALLOC,   16'h0000, 16'd100,  1, STS_OK,       16'h0000, 0);
    add_row(CMD_ALLOC,   16'hffff, 16'd50,   1, STS_OK,       16'hffff, 100);
    add_row(CMD_ALLOC,   16'h0003, 16'd20,   0, STS_OK,       16'h0000, 0);
    add_row(CMD_ALLOC,   16'hffff, 16'd7,    0, STS_OK,       16'h0000, 0);
    add_row(CMD_FREE,    16'h0000, 16'h0000, 1, STS_NOTFOUND, 16'h0000, 0);
    add_row(CMD_FREE,    16'h1234, 16'hffff, 1, STS_NOTFOUND, 16'h1234, 0);
    // duplicate handle: newest copy goes first, then the zero-length oldest
    add_row(CMD_FREE,    16'hffff, 16'h0000, 0, STS_OK,       16'h0000, 0);
    add_row(CMD_FREE,    16'h0001, 16'h0000, 0, STS_OK,       16'h0000, 0);
    add_row(CMD_FREE,    16'hffff, 16'h0000, 0, STS_OK,       16'h0000, 0);
    add_row(CMD_QUEUE,   16'h0000, 16'h0000, 1, STS_OK,       16'h0000, 0);
    add_row(CMD_QUEUE,   16'h0003, 16'h0000, 1, STS_OK,       16'h0003, 0);
    for (n = 0; n < DEPTH - 2; n++)
      add_row(CMD_QUEUE, 16'h0009, 16'h0000, 1, STS_OK,       16'h0009, 0);
    add_row(CMD_QUEUE,   16'h8000, 16'h0000, 1, STS_FULL,     16'h8000, 0);
    add_row(CMD_RECLAIM, 16'h0000, 16'h0000, 1, STS_NOTFOUND, 16'h0009, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].handle, dir_rows[i].size,
                dir_rows[i].typed, dir_rows[i].answer);

    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n >= RAND_ITEMS - 40) idle_on = 1'b0;
      if (n % 50 == 0) fill_left = MAXB + 1;
      s = 16'($urandom);
      if (fill_left > 0) begin
        // fill the table, one past full, then free the oldest block
        fill_left--;
        c = CMD_ALLOC;
        h = rand_handle();
        s = 16'($urandom_range(0, 40));
        if (fill_left == 0) drain_oldest = 1'b1;
      end else if (drain_oldest) begin
        drain_oldest = 1'b0;
        c = CMD_FREE;
        h = (blk_cnt > 0) ? tbl_owner[0] : rand_handle();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          c = CMD_ALLOC;
          h = rand_handle();
          r = $urandom_range(0, 99);
          if (r < 80)      s = 16'($urandom_range(0, 40));
          else if (r < 95) s = 16'($urandom_range(0, POOL - 1));
        end else if (r < 75) begin
          c = CMD_FREE;
          h = live_or_rand();
        end else if (r < 88) begin
          c = CMD_QUEUE;
          h = live_or_rand();
        end else begin
          c = CMD_RECLAIM;
          h = rand_handle();
        end
      end
      send_word(c, h, s, 1'b0, no_ans);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0 && pending_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
